// File: design/mos_pkg.sv
// ----------------------------------------------------------------------------
// mos_pkg
// Shared constants, codes and types of the median-of-sample-set unit.
// ----------------------------------------------------------------------------
package mos_pkg;

   localparam int MAX_SAMPLES  = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int ADDR_W       = $clog2(MAX_SAMPLES);
   localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
   localparam int STATUS_W     = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      logic       op;
      sample_type a;
      sample_type b;
   } alu_req_type;

   typedef struct packed {
      logic       neg;
      sample_type half;
   } alu_rsp_type;

endpackage

// File: design/median_of_sample_set_unit.sv
// ----------------------------------------------------------------------------
// median_of_sample_set_unit
// Median of a set of signed samples kept in sorted order in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per sample: req_sample, req_sample_present
//   (0 for a bare end marker) and req_last (closes the set). req_stall is high
//   while a transaction is being worked on.
//   rsp_* carries one transaction per set, on the item with req_last:
//   rsp_median and rsp_status (ok, empty set, overflow; median 0 unless ok).
// Operation:
//   A sample is inserted by walking down the sorted RAM with one shared
//   compare, one entry per cycle, moving larger entries up one place and
//   writing the sample where the walk stops. The first sample of a set, a
//   dropped sample and a bare item need no walk. Closing a set reads the
//   middle entry (odd count) or, through the single read port, both middle
//   entries, then adds and halves them (even count); an error skips the reads.
// Reset clears the count, overflow flag and output valid; the RAM is not
// cleared, entries above the count are never read.
// A stalled result holds in the output register; the unit keeps taking
// samples and only waits when the next set's result is ready.
// ----------------------------------------------------------------------------
module median_of_sample_set_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [mos_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic                                   req_sample_present,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mos_pkg::SAMPLE_WIDTH-1:0] rsp_median,
   output logic [mos_pkg::STATUS_W-1:0]           rsp_status
);

   localparam int AW = mos_pkg::ADDR_W;
   localparam int CW = mos_pkg::CNT_W;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CMP     = 3'd1;
   localparam logic [2:0] S_PLACE   = 3'd2;
   localparam logic [2:0] S_MED     = 3'd3;
   localparam logic [2:0] S_MID_B   = 3'd4;
   localparam logic [2:0] S_MID_SUM = 3'd5;
   localparam logic [2:0] S_OUT     = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                overflow_ff, overflow_in;
   logic [AW-1:0]       pos_ff, pos_in;
   mos_pkg::sample_type sample_ff, sample_in;
   logic                last_ff, last_in;
   mos_pkg::sample_type hold_ff, hold_in;
   mos_pkg::sample_type res_median_ff, res_median_in;
   logic [mos_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mos_pkg::sample_type rsp_median_ff, rsp_median_in;
   logic [mos_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   mos_pkg::sample_type wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   mos_pkg::sample_type rd_data;

   mos_pkg::alu_req_type alu_req;
   mos_pkg::alu_rsp_type alu_rsp;

   logic accept;
   logic out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   mos_ram #(
      .WIDTH (mos_pkg::SAMPLE_WIDTH),
      .DEPTH (mos_pkg::MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mos_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      pos_in        = pos_ff;
      sample_in     = sample_ff;
      last_in       = last_ff;
      hold_in       = hold_ff;
      res_median_in = res_median_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_median_in = rsp_median_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = sample_ff;
      rd_en         = 1'b0;
      rd_addr       = pos_ff - AW'(1);
      alu_req.op    = mos_pkg::ALU_SUB;
      alu_req.a     = sample_ff;
      alu_req.b     = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               last_in   = req_last;
               if (req_sample_present && count_ff < CW'(mos_pkg::MAX_SAMPLES)) begin
                  if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = req_sample;
                     count_in = CW'(1);
                     state_in = req_last ? S_MED : S_IDLE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(count_ff - CW'(1));
                     pos_in   = AW'(count_ff);
                     state_in = S_CMP;
                  end
               end else begin
                  if (req_sample_present) begin
                     overflow_in = 1'b1;
                  end
                  state_in = req_last ? S_MED : S_IDLE;
               end
            end
         end
         S_CMP: begin
            // alu computes sample - entry; negative means the entry moves up
            wr_en = 1'b1;
            if (alu_rsp.neg) begin
               wr_data = rd_data;
               if (pos_ff == AW'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff - AW'(2);
                  pos_in  = pos_ff - AW'(1);
               end
            end else begin
               count_in = count_ff + CW'(1);
               state_in = last_ff ? S_MED : S_IDLE;
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = count_ff + CW'(1);
            state_in = last_ff ? S_MED : S_IDLE;
         end
         S_MED: begin
            res_median_in = '0;
            if (overflow_ff) begin
               res_status_in = mos_pkg::STATUS_OVERFLOW;
               state_in      = S_OUT;
            end else if (count_ff == '0) begin
               res_status_in = mos_pkg::STATUS_EMPTY;
               state_in      = S_OUT;
            end else begin
               res_status_in = mos_pkg::STATUS_OK;
               rd_en         = 1'b1;
               rd_addr       = AW'(count_ff >> 1);
               state_in      = S_MID_B;
            end
         end
         S_MID_B: begin
            if (count_ff[0]) begin
               res_median_in = rd_data;
               state_in      = S_OUT;
            end else begin
               hold_in  = rd_data;
               rd_en    = 1'b1;
               rd_addr  = AW'((count_ff >> 1) - CW'(1));
               state_in = S_MID_SUM;
            end
         end
         S_MID_SUM: begin
            alu_req.op    = mos_pkg::ALU_ADD;
            alu_req.a     = hold_ff;
            res_median_in = alu_rsp.half;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = res_median_ff;
               rsp_status_in = res_status_ff;
               count_in      = '0;
               overflow_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      sample_ff     <= sample_in;
      last_ff       <= last_in;
      hold_ff       <= hold_in;
      res_median_ff <= res_median_in;
      res_status_ff <= res_status_in;
      rsp_median_ff <= rsp_median_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(mos_pkg::MAX_SAMPLES))
      else $error("sample count beyond store depth");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> count_ff == CW'(mos_pkg::MAX_SAMPLES))
      else $error("overflow flagged with store not full");

   a_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (count_ff == '0 && !overflow_ff))
      else $error("set state not cleared after result");

   a_error_zero_median: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != mos_pkg::STATUS_OK) |-> rsp_median == '0)
      else $error("nonzero median on error status");
`endif

endmodule

// File: design/mos_ram.sv
// ----------------------------------------------------------------------------
// mos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mos_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/mos_alu.sv
// ----------------------------------------------------------------------------
// mos_alu
// Shared adder: subtract for the insertion compare, add and halve (truncating
// toward zero) for the even-count median.
// ----------------------------------------------------------------------------
module mos_alu (
   input  mos_pkg::alu_req_type req,
   output mos_pkg::alu_rsp_type rsp
);

   localparam int SW = mos_pkg::SAMPLE_WIDTH;

   logic [SW:0] a_x;
   logic [SW:0] b_x;
   logic [SW:0] sum;
   logic [SW:0] adj;

   always_comb begin
      a_x = {req.a[SW-1], req.a};
      b_x = (req.op == mos_pkg::ALU_SUB) ? ~{req.b[SW-1], req.b} : {req.b[SW-1], req.b};
      sum = a_x + b_x + {{SW{1'b0}}, req.op};
      // negative odd sum: bump by one so the arithmetic shift rounds toward zero
      adj = sum + {{SW{1'b0}}, sum[SW] & sum[0]};
      rsp.neg  = sum[SW];
      rsp.half = adj[SW:1];
   end

endmodule
